>>> design/abrei_pkg.sv
// Package with the shared types, constants and bank mapping functions of the banked register file.
package abrei_pkg;

  typedef enum logic [3:0] {
    FUNC_RD_REG  = 4'd0,
    FUNC_WR_REG  = 4'd1,
    FUNC_WR_CPSR = 4'd2,
    FUNC_EXC     = 4'd3,
    FUNC_TAKE    = 4'd4,
    FUNC_IME     = 4'd5,
    FUNC_IE      = 4'd6,
    FUNC_ACK     = 4'd7,
    FUNC_RAISE   = 4'd8,
    FUNC_HALT    = 4'd9,
    FUNC_UNHALT  = 4'd10,
    FUNC_STATUS  = 4'd11
  } func_e;

  typedef enum logic [2:0] {
    BANK_USR  = 3'd0,
    BANK_FIQ  = 3'd1,
    BANK_IRQ  = 3'd2,
    BANK_SVC  = 3'd3,
    BANK_ABT  = 3'd4,
    BANK_UND  = 3'd5,
    BANK_NONE = 3'd7
  } bank_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EXC,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    CFG_SUB_CPU     = 2'd0,
    CFG_LEGACY      = 2'd1,
    CFG_VECTOR_BASE = 2'd2
  } cfg_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic exc;
  } cmd_t;

  typedef struct packed {
    logic exc_needed;
  } status_t;

  localparam int unsigned NumRegs  = 31;
  localparam int unsigned NumSpsr  = 5;

  localparam logic [4:0]  PhysPc      = 5'd15;
  localparam logic [4:0]  PhysIrqBase = 5'd23;
  localparam logic [4:0]  PhysSvcBase = 5'd25;
  localparam logic [4:0]  PhysAbtBase = 5'd27;
  localparam logic [4:0]  PhysUndBase = 5'd29;
  localparam logic [3:0]  RegLr       = 4'd14;
  localparam logic [4:0]  IrqVector   = 5'h18;

  localparam logic [31:0] CpsrReset   = 32'h0000_00D3;
  localparam logic [31:0] IeMaskArm7  = 32'h01FF_3FFF;
  localparam logic [31:0] IeMaskGba   = 32'h0000_3FFF;
  localparam logic [31:0] IeMaskArm9  = 32'h003F_3F7F;

  localparam logic [4:0] ExcModes [8] = '{
    5'h13, 5'h1B, 5'h13, 5'h17, 5'h17, 5'h13, 5'h12, 5'h11
  };

  function automatic bank_e bank_of_mode(logic [4:0] mode);
    bank_e b;
    case (mode)
      5'h10, 5'h1F: b = BANK_USR;
      5'h11: b = BANK_FIQ;
      5'h12: b = BANK_IRQ;
      5'h13: b = BANK_SVC;
      5'h17: b = BANK_ABT;
      5'h1B: b = BANK_UND;
      default: b = BANK_NONE;
    endcase
    return b;
  endfunction

  function automatic logic [4:0] phys_idx(bank_e bank, logic [3:0] idx);
    logic [4:0] p;
    logic [4:0] k;
    p = {1'b0, idx};
    k = {4'b0000, ~idx[0]};
    if (bank == BANK_FIQ && idx >= 4'd8 && idx <= 4'd14) begin
      p = {1'b0, idx} + 5'd8;
    end else if (idx == 4'd13 || idx == 4'd14) begin
      case (bank)
        BANK_IRQ: p = PhysIrqBase + k;
        BANK_SVC: p = PhysSvcBase + k;
        BANK_ABT: p = PhysAbtBase + k;
        BANK_UND: p = PhysUndBase + k;
        default: p = {1'b0, idx};
      endcase
    end
    return p;
  endfunction

  function automatic logic spsr_present(bank_e bank);
    return bank == BANK_FIQ || bank == BANK_SVC || bank == BANK_ABT ||
           bank == BANK_IRQ || bank == BANK_UND;
  endfunction

  function automatic logic [2:0] spsr_idx(bank_e bank);
    logic [2:0] s;
    case (bank)
      BANK_FIQ: s = 3'd0;
      BANK_SVC: s = 3'd1;
      BANK_ABT: s = 3'd2;
      BANK_IRQ: s = 3'd3;
      BANK_UND: s = 3'd4;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

>>> design/abrei_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module abrei_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  abrei_pkg::status_t  status_i,
  output abrei_pkg::cmd_t     cmd_o,
  output logic                busy,
  output logic                done_o
);
  import abrei_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = status_i.exc_needed ? ST_EXC : ST_RESP;
      end
      ST_EXC: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = accept ? ST_EXEC : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state_q == ST_EXEC) || (state_q == ST_EXC);
    done_o     = (state_q == ST_RESP);
    cmd_o.load = start && !((state_q == ST_EXEC) || (state_q == ST_EXC));
    cmd_o.exec = (state_q == ST_EXEC);
    cmd_o.exc  = (state_q == ST_EXC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/abrei_datapath.sv
// Datapath holding the banked registers, status words, interrupt state and configuration.
module abrei_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic [3:0]          func_i,
  input  logic [3:0]          reg_index_i,
  input  logic [31:0]         data_value_i,
  input  logic [31:0]         write_mask_i,
  input  logic                save_spsr_i,
  input  logic [4:0]          vector_offset_i,
  input  logic [4:0]          bit_number_i,
  input  abrei_pkg::cmd_t     cmd_i,
  output abrei_pkg::status_t  status_o,
  output logic [31:0]         read_data_o,
  output logic [31:0]         cpsr_now_o,
  output logic [31:0]         spsr_now_o,
  output logic                spsr_present_o,
  output logic                irq_request_o,
  output logic [1:0]          irq_delay_o,
  output logic [7:0]          halt_bits_o,
  output logic                mode_unknown_o
);
  import abrei_pkg::*;

  logic        sub_cpu_q;
  logic        legacy_q;
  logic [31:0] vector_base_q;

  logic [3:0]  func_q;
  logic [3:0]  ridx_q;
  logic [31:0] data_q;
  logic [31:0] mask_q;
  logic        save_q;
  logic [4:0]  vec_q;
  logic [4:0]  bit_q;

  logic [31:0] regs_q [NumRegs];
  logic [31:0] spsr_q [NumSpsr];
  logic [31:0] cpsr_q, cpsr_d;
  bank_e       bank_q, bank_d;
  logic        ime_q, ime_d;
  logic [31:0] ie_q, ie_d;
  logic [31:0] irf_q, irf_d;
  logic [7:0]  halt_q, halt_d;
  logic [31:0] rd_q;

  logic        pending;
  logic        pending_raise;
  logic [31:0] irf_raise;
  logic [31:0] ie_mask;
  logic [31:0] exc_cpsr;
  logic        cpsr_wr;
  logic [31:0] cpsr_val;
  logic        cpsr_save;
  bank_e       new_bank;
  bank_e       mode_bank;
  logic        spsr_wr;
  logic [4:0]  rd_addr;
  logic [31:0] rd_word;
  logic        reg_wr;
  logic [4:0]  reg_wr_addr;
  logic [4:0]  lr_addr;
  logic [31:0] lr_val;
  logic [31:0] pc_sum;
  logic [31:0] pc_val;
  logic [31:0] base;
  logic [4:0]  vec_eff;
  logic [31:0] cur_spsr;
  logic        cur_present;

  assign pending = ime_q && ((ie_q & irf_q) != 32'd0) && !cpsr_q[7];

  assign status_o.exc_needed = (func_q == FUNC_EXC) || (func_q == FUNC_TAKE && pending);

  assign cur_present = spsr_present(bank_q);
  assign cur_spsr    = cur_present ? spsr_q[spsr_idx(bank_q)] : 32'd0;

  assign irf_raise     = irf_q | (32'd1 << bit_q);
  assign pending_raise = ime_q && ((ie_q & irf_raise) != 32'd0) && !cpsr_q[7];
  assign ie_mask       = mask_q & (sub_cpu_q ? (legacy_q ? IeMaskGba : IeMaskArm7) : IeMaskArm9);

  assign vec_eff  = (func_q == FUNC_TAKE) ? IrqVector : vec_q;
  assign exc_cpsr = {cpsr_q[31:8], 1'b1, cpsr_q[6], 1'b0, ExcModes[vec_eff[4:2]]};

  assign cpsr_wr   = cmd_i.exec && ((func_q == FUNC_WR_CPSR) || status_o.exc_needed);
  assign cpsr_val  = (func_q == FUNC_WR_CPSR) ? data_q : exc_cpsr;
  assign cpsr_save = (func_q == FUNC_WR_CPSR) ? save_q : 1'b1;
  assign mode_bank = bank_of_mode(cpsr_val[4:0]);
  assign new_bank  = ((cpsr_val[4:0] != cpsr_q[4:0]) && (mode_bank != BANK_NONE)) ?
                     mode_bank : bank_q;
  assign spsr_wr   = cpsr_wr && cpsr_save && spsr_present(new_bank);

  assign rd_addr = cmd_i.exc ? PhysPc : phys_idx(bank_q, ridx_q);
  assign rd_word = regs_q[rd_addr];

  assign reg_wr      = cmd_i.exec && (func_q == FUNC_WR_REG);
  assign reg_wr_addr = phys_idx(bank_q, ridx_q);
  assign lr_addr     = phys_idx(bank_q, RegLr);
  assign lr_val      = rd_word + (cur_present ? {30'd0, cur_spsr[5], 1'b0} : 32'd0);
  assign base        = sub_cpu_q ? 32'd0 : vector_base_q;
  assign pc_sum      = base + {27'd0, vec_eff};
  assign pc_val      = {pc_sum[31:2] + 30'd1, 2'b00};

  always_comb begin
    cpsr_d = cpsr_q;
    bank_d = bank_q;
    ime_d  = ime_q;
    ie_d   = ie_q;
    irf_d  = irf_q;
    halt_d = halt_q;
    if (cpsr_wr) begin
      cpsr_d = cpsr_val;
      bank_d = new_bank;
    end
    if (cmd_i.exec) begin
      case (func_q)
        FUNC_TAKE: begin
          if (pending) halt_d[0] = 1'b0;
        end
        FUNC_IME: ime_d = data_q[0];
        FUNC_IE: ie_d = (ie_q & ~ie_mask) | (data_q & ie_mask);
        FUNC_ACK: irf_d = irf_q & ~(data_q & mask_q);
        FUNC_RAISE: begin
          irf_d = irf_raise;
          if (((ie_q & irf_raise) != 32'd0) && !pending_raise && (ime_q || sub_cpu_q)) begin
            halt_d[0] = 1'b0;
          end
        end
        FUNC_HALT: begin
          if (!bit_q[4] && !bit_q[3]) halt_d[bit_q[2:0]] = 1'b1;
        end
        FUNC_UNHALT: begin
          if (!bit_q[4] && !bit_q[3]) halt_d[bit_q[2:0]] = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_cpu_q     <= 1'b0;
      legacy_q      <= 1'b0;
      vector_base_q <= 32'hFFFF_0000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SUB_CPU:     sub_cpu_q <= cfg_data_i[0];
        CFG_LEGACY:      legacy_q <= cfg_data_i[0];
        CFG_VECTOR_BASE: vector_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      ridx_q <= reg_index_i;
      data_q <= data_value_i;
      mask_q <= write_mask_i;
      save_q <= save_spsr_i;
      vec_q  <= vector_offset_i;
      bit_q  <= bit_number_i;
    end
    if (cmd_i.exec) begin
      rd_q <= (func_q == FUNC_RD_REG) ? rd_word : 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= 32'd0;
      for (int i = 0; i < NumSpsr; i++) spsr_q[i] <= 32'd0;
      cpsr_q <= CpsrReset;
      bank_q <= BANK_SVC;
      ime_q  <= 1'b0;
      ie_q   <= 32'd0;
      irf_q  <= 32'd0;
      halt_q <= 8'd0;
    end else begin
      if (reg_wr) regs_q[reg_wr_addr] <= data_q;
      if (cmd_i.exc) begin
        regs_q[lr_addr] <= lr_val;
        regs_q[PhysPc]  <= pc_val;
      end
      if (spsr_wr) spsr_q[spsr_idx(new_bank)] <= cpsr_q;
      cpsr_q <= cpsr_d;
      bank_q <= bank_d;
      ime_q  <= ime_d;
      ie_q   <= ie_d;
      irf_q  <= irf_d;
      halt_q <= halt_d;
    end
  end

  assign read_data_o    = rd_q;
  assign cpsr_now_o     = cpsr_q;
  assign spsr_now_o     = cur_spsr;
  assign spsr_present_o = cur_present;
  assign irq_request_o  = pending;
  assign irq_delay_o    = (sub_cpu_q && !legacy_q) ? 2'd2 : 2'd1;
  assign halt_bits_o    = halt_q;
  assign mode_unknown_o = (bank_of_mode(cpsr_q[4:0]) == BANK_NONE);

endmodule

>>> design/arm_banked_regs_exception_irq.sv
// Top level of the banked ARM register file with its interrupt controller.
//
//   Channel  Handshake              Payload
//   command  start in, busy out     func, reg_index, data_value, write_mask, save_spsr,
//                                   vector_offset, bit_number
//   result   done_o strobe          read_data, cpsr_now, spsr_now, spsr_present,
//                                   irq_request, irq_delay, halt_bits, mode_unknown
//   config   cfg_valid_i/ready_o    cfg_index_i, cfg_data_i
//
// A request passes through the execute state and then the result state, which raises the
// result strobe; an exception entry or a taken interrupt passes through the exception state
// between them, which writes r14 and r15.
// The next request may be accepted in the cycle that shows the result, never while busy is
// high. Reset initialises the register file and state, not the request or read latches; the
// receiver cannot stall the one-cycle result.
module arm_banked_regs_exception_irq (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  func_i,
  input  logic [3:0]  reg_index_i,
  input  logic [31:0] data_value_i,
  input  logic [31:0] write_mask_i,
  input  logic        save_spsr_i,
  input  logic [4:0]  vector_offset_i,
  input  logic [4:0]  bit_number_i,
  output logic        done_o,
  output logic [31:0] read_data_o,
  output logic [31:0] cpsr_now_o,
  output logic [31:0] spsr_now_o,
  output logic        spsr_present_o,
  output logic        irq_request_o,
  output logic [1:0]  irq_delay_o,
  output logic [7:0]  halt_bits_o,
  output logic        mode_unknown_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import abrei_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  abrei_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  abrei_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (func_i),
    .reg_index_i     (reg_index_i),
    .data_value_i    (data_value_i),
    .write_mask_i    (write_mask_i),
    .save_spsr_i     (save_spsr_i),
    .vector_offset_i (vector_offset_i),
    .bit_number_i    (bit_number_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .read_data_o     (read_data_o),
    .cpsr_now_o      (cpsr_now_o),
    .spsr_now_o      (spsr_now_o),
    .spsr_present_o  (spsr_present_o),
    .irq_request_o   (irq_request_o),
    .irq_delay_o     (irq_delay_o),
    .halt_bits_o     (halt_bits_o),
    .mode_unknown_o  (mode_unknown_o)
  );

endmodule
